[design/assert_macros.svh]
// assertion macros shared by the crossover design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LRX_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define LRX_CHECK_NEXT(name, cond, conseq, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

[design/lrx_pkg.sv]
// shared constants, types and width helpers for the crossover filter pair
package lrx_pkg;

	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int COEF_FRAC_BITS_DEF = 28;
	localparam int TAPS               = 4;
	localparam int TAP_IDX_W          = 2;
	localparam int HIST_BITS          = 32;
	localparam int HIST_EXTRA         = 8;
	localparam int COEF_BITS          = 32;
	localparam int GAIN_BITS          = 31;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 32;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEN1      = 3'd0,
		REG_DEN2      = 3'd1,
		REG_DEN3      = 3'd2,
		REG_DEN4      = 3'd3,
		REG_LOW_GAIN  = 3'd4,
		REG_HIGH_GAIN = 3'd5
	} lrx_reg_t;

	// feedback stage control
	typedef struct packed {
		logic load;
		logic clr;
	} lrx_step_t;

	// width of one rounded gain product
	function automatic int ff_round_width(int sb, int cf);
		return sb + GAIN_BITS + 2 - (cf - HIST_EXTRA);
	endfunction

	// width of the weighted feedforward sum
	function automatic int ff_width(int sb, int cf);
		return ff_round_width(sb, cf) + 5;
	endfunction

	// width of the summed feedback terms
	function automatic int fb_width(int cf);
		return COEF_BITS + HIST_BITS + 1 - cf + 2;
	endfunction

endpackage

[design/crossover_filter_pair_unit.sv]
// top level of the fourth-order crossover filter pair with stream ports
// One sample word in, one word holding a low band and a high band sample out.
// The unit takes a word in every cycle when not stalled; each word passes an
// input register, a feedforward stage (ten gain products of the new sample and
// the four previous ones, weighted 1 4 6 4 1 and 1 -4 6 -4 1) and a feedback
// stage that forms both bands from the feedforward sums and the four past
// outputs of each band, saturates the 32-bit history and rounds and saturates
// the output. The feedback stage closes the recursion combinationally, so its
// four coefficient multiplies per band and the following sum set the clock
// rate. A word with tuser high clears all history and gives no result.
// Coefficients are Q3 fixed point, written over the cfg port only while no
// word is in flight, which the user must ensure as the block does not; history
// survives a coefficient write. The result register decouples the two sides,
// so input is taken while a result waits, until all stages are full.
`include "assert_macros.svh"

module crossover_filter_pair_unit #(
	parameter int SAMPLE_BITS    = lrx_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = lrx_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// input words
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]   s_tdata,   // sample
	input  logic                                       s_tuser,   // cmd: 1 clears history
	// result words
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata, // low_out, high_out
	// configuration writes
	input  logic                                       cfg_we,
	input  logic [lrx_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [lrx_pkg::CFG_DATA_W-1:0]             cfg_data
);
	import lrx_pkg::*;

	localparam int OutW = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int Fw   = ff_width(SAMPLE_BITS, COEF_FRAC_BITS);

	// coefficient registers
	logic signed [COEF_BITS-1:0] den_q [TAPS];
	logic [GAIN_BITS-1:0]        low_gain_q;
	logic [GAIN_BITS-1:0]        high_gain_q;

	// input history, newest first
	logic signed [SAMPLE_BITS-1:0] xh_q [TAPS];

	// stage 1: sample with history snapshot
	logic                          v_s1;
	logic                          clr_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1 [TAPS+1];

	// stage 2: feedforward sums
	logic                 v_s2;
	logic                 clr_s2;
	logic signed [Fw-1:0] ff_low_s2;
	logic signed [Fw-1:0] ff_high_s2;

	// result
	logic                          vo_q;
	logic signed [SAMPLE_BITS-1:0] low_out;
	logic signed [SAMPLE_BITS-1:0] high_out;

	logic                          acc_in;
	logic                          mv1;
	logic                          mv2;
	logic                          rdy2;
	logic                          rdy_out;
	logic signed [SAMPLE_BITS-1:0] sample;
	lrx_step_t                     step;

	// config writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				den_q[k] <= '0;
			end
			low_gain_q  <= '0;
			high_gain_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEN1, REG_DEN2, REG_DEN3, REG_DEN4: begin
					den_q[cfg_index[TAP_IDX_W-1:0]] <= cfg_data[COEF_BITS-1:0];
				end
				REG_LOW_GAIN: begin
					low_gain_q <= cfg_data[GAIN_BITS-1:0];
				end
				REG_HIGH_GAIN: begin
					high_gain_q <= cfg_data[GAIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline flow: clear words leave stage 2 without needing the result slot
	assign rdy_out  = !vo_q || m_tready;
	assign mv2      = v_s2 && (clr_s2 || rdy_out);
	assign rdy2     = !v_s2 || mv2;
	assign mv1      = v_s1 && rdy2;
	assign s_tready = !v_s1 || mv1;
	assign acc_in   = s_tvalid && s_tready;
	assign sample   = s_tdata[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			vo_q   <= 1'b0;
			clr_s1 <= 1'b0;
			clr_s2 <= 1'b0;
			for (int k = 0; k < TAPS; k++) begin
				xh_q[k] <= '0;
			end
		end else begin
			v_s1 <= acc_in || (v_s1 && !mv1);
			v_s2 <= mv1 || (v_s2 && !mv2);
			vo_q <= (mv2 && !clr_s2) || (vo_q && !m_tready);
			if (acc_in) begin
				clr_s1 <= s_tuser;
				if (s_tuser) begin
					for (int k = 0; k < TAPS; k++) begin
						xh_q[k] <= '0;
					end
				end else begin
					for (int k = TAPS - 1; k > 0; k--) begin
						xh_q[k] <= xh_q[k-1];
					end
					xh_q[0] <= sample;
				end
			end
			if (mv1) begin
				clr_s2 <= clr_s1;
			end
		end
	end

	// sample plus the history it is filtered against
	always_ff @(posedge clk) begin
		if (acc_in) begin
			x_s1[0] <= sample;
			for (int k = 0; k < TAPS; k++) begin
				x_s1[k+1] <= xh_q[k];
			end
		end
	end

	lrx_ff #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_ff (
		.clk        (clk),
		.en         (mv1),
		.x          (x_s1),
		.low_gain   (low_gain_q),
		.high_gain  (high_gain_q),
		.ff_low_s2  (ff_low_s2),
		.ff_high_s2 (ff_high_s2)
	);

	assign step.load = mv2;
	assign step.clr  = clr_s2;

	lrx_fb #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_fb (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.ff_low_s2  (ff_low_s2),
		.ff_high_s2 (ff_high_s2),
		.den        (den_q),
		.low_out    (low_out),
		.high_out   (high_out)
	);

	assign m_tvalid = vo_q;
	assign m_tdata  = OutW'({high_out, low_out});

	`LRX_CHECK_NEXT(a_in_hist_clear, acc_in && s_tuser, xh_q[0] == '0 && xh_q[TAPS-1] == '0, "input history not cleared")
	`LRX_CHECK(a_out_source, $rose(m_tvalid) |-> $past(v_s2 && !clr_s2), "result without a filter word")
	`LRX_CHECK(a_full_stall, (vo_q && !m_tready && v_s1 && v_s2 && !clr_s2) |-> !s_tready, "input taken while pipeline full")

endmodule

[design/lrx_ff.sv]
// feedforward stage: gain products of five input samples, binomial weighting
module lrx_ff #(
	parameter int SAMPLE_BITS    = lrx_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = lrx_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [SAMPLE_BITS-1:0]          x [lrx_pkg::TAPS+1],
	input  logic [lrx_pkg::GAIN_BITS-1:0]          low_gain,
	input  logic [lrx_pkg::GAIN_BITS-1:0]          high_gain,
	output logic signed [lrx_pkg::ff_width(SAMPLE_BITS, COEF_FRAC_BITS)-1:0] ff_low_s2,
	output logic signed [lrx_pkg::ff_width(SAMPLE_BITS, COEF_FRAC_BITS)-1:0] ff_high_s2
);
	import lrx_pkg::*;

	localparam int Ns = COEF_FRAC_BITS - HIST_EXTRA;
	localparam int Pw = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int Rw = Pw + 1 - Ns;
	localparam int Fw = ff_width(SAMPLE_BITS, COEF_FRAC_BITS);
	localparam logic [Pw:0] Half = {{(Pw - Ns + 1){1'b0}}, 1'b1, {(Ns - 1){1'b0}}};

	logic signed [Fw-1:0] el [TAPS+1];
	logic signed [Fw-1:0] eh [TAPS+1];
	logic signed [Fw-1:0] sum_low;
	logic signed [Fw-1:0] sum_high;

	for (genvar i = 0; i <= TAPS; i++) begin : g_tap
		logic signed [Pw-1:0] pl;
		logic signed [Pw-1:0] ph;
		logic [Pw:0]          ql;
		logic [Pw:0]          qh;
		logic signed [Rw-1:0] rl;
		logic signed [Rw-1:0] rh;

		assign pl = $signed({1'b0, low_gain}) * x[i];
		assign ph = $signed({1'b0, high_gain}) * x[i];
		// round half up, then drop the low fraction bits
		assign ql = {pl[Pw-1], pl} + Half;
		assign qh = {ph[Pw-1], ph} + Half;
		assign rl = ql[Pw:Ns];
		assign rh = qh[Pw:Ns];
		assign el[i] = Fw'(rl);
		assign eh[i] = Fw'(rh);
	end

	// 1 4 6 4 1 and 1 -4 6 -4 1
	assign sum_low  = el[0] + (el[1] <<< 2) + (el[2] <<< 2) + (el[2] <<< 1)
		+ (el[3] <<< 2) + el[4];
	assign sum_high = eh[0] - (eh[1] <<< 2) + (eh[2] <<< 2) + (eh[2] <<< 1)
		- (eh[3] <<< 2) + eh[4];

	always_ff @(posedge clk) begin
		if (en) begin
			ff_low_s2  <= sum_low;
			ff_high_s2 <= sum_high;
		end
	end

endmodule

[design/lrx_fb.sv]
// feedback stage: per-band output history, recursion and output rounding
`include "assert_macros.svh"

module lrx_fb #(
	parameter int SAMPLE_BITS    = lrx_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = lrx_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lrx_pkg::lrx_step_t                     step,
	input  logic signed [lrx_pkg::ff_width(SAMPLE_BITS, COEF_FRAC_BITS)-1:0] ff_low_s2,
	input  logic signed [lrx_pkg::ff_width(SAMPLE_BITS, COEF_FRAC_BITS)-1:0] ff_high_s2,
	input  logic signed [lrx_pkg::COEF_BITS-1:0]   den [lrx_pkg::TAPS],
	output logic signed [SAMPLE_BITS-1:0]          low_out,
	output logic signed [SAMPLE_BITS-1:0]          high_out
);
	import lrx_pkg::*;

	localparam int Fw   = ff_width(SAMPLE_BITS, COEF_FRAC_BITS);
	localparam int Fbw  = fb_width(COEF_FRAC_BITS);
	localparam int Accw = ((Fw > Fbw) ? Fw : Fbw) + 1;
	localparam int Pw   = COEF_BITS + HIST_BITS;
	localparam int Rw   = Pw + 1 - COEF_FRAC_BITS;
	localparam int Ow   = Accw + 1 - HIST_EXTRA;
	localparam logic [Pw:0] HalfFb =
		{{(Pw - COEF_FRAC_BITS + 1){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
	localparam logic [Accw:0] HalfOut =
		{{(Accw - HIST_EXTRA + 1){1'b0}}, 1'b1, {(HIST_EXTRA - 1){1'b0}}};
	localparam logic signed [Accw-1:0] YMax =
		{{(Accw - HIST_BITS + 1){1'b0}}, {(HIST_BITS - 1){1'b1}}};
	localparam logic signed [Accw-1:0] YMin = ~YMax;
	localparam logic signed [Ow-1:0] OMax =
		{{(Ow - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [Ow-1:0] OMin = ~OMax;

	wire [1:0]                   hist_clear;
	wire signed [SAMPLE_BITS-1:0] band_out [2];

	for (genvar b = 0; b < 2; b++) begin : g_band
		logic signed [HIST_BITS-1:0]   y_q [TAPS];
		logic signed [SAMPLE_BITS-1:0] out_q;
		logic signed [Fw-1:0]          ff;
		logic signed [Fbw-1:0]         fb_sum;
		logic signed [Fbw-1:0]         fe [TAPS];
		logic signed [Accw-1:0]        acc;
		logic [Accw:0]                 acc_rnd;
		logic signed [Ow-1:0]          acc_out;
		logic signed [HIST_BITS-1:0]   y_new;
		logic signed [SAMPLE_BITS-1:0] o_new;
		logic                          zero;

		assign ff = (b == 0) ? ff_low_s2 : ff_high_s2;

		for (genvar k = 0; k < TAPS; k++) begin : g_tap
			logic signed [Pw-1:0] p;
			logic [Pw:0]          q;
			logic signed [Rw-1:0] r;

			assign p     = den[k] * y_q[k];
			assign q     = {p[Pw-1], p} + HalfFb;
			assign r     = q[Pw:COEF_FRAC_BITS];
			assign fe[k] = Fbw'(r);
		end

		always_comb begin
			fb_sum = '0;
			for (int k = 0; k < TAPS; k++) begin
				fb_sum = fb_sum + fe[k];
			end
		end

		assign acc     = Accw'(ff) - Accw'(fb_sum);
		assign acc_rnd = {acc[Accw-1], acc} + HalfOut;
		assign acc_out = acc_rnd[Accw:HIST_EXTRA];

		// history saturates to 32 bits, output to the sample range
		always_comb begin
			if (acc > YMax) begin
				y_new = YMax[HIST_BITS-1:0];
			end else if (acc < YMin) begin
				y_new = YMin[HIST_BITS-1:0];
			end else begin
				y_new = acc[HIST_BITS-1:0];
			end
			if (acc_out > OMax) begin
				o_new = OMax[SAMPLE_BITS-1:0];
			end else if (acc_out < OMin) begin
				o_new = OMin[SAMPLE_BITS-1:0];
			end else begin
				o_new = acc_out[SAMPLE_BITS-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int k = 0; k < TAPS; k++) begin
					y_q[k] <= '0;
				end
			end else if (step.load) begin
				if (step.clr) begin
					for (int k = 0; k < TAPS; k++) begin
						y_q[k] <= '0;
					end
				end else begin
					for (int k = TAPS - 1; k > 0; k--) begin
						y_q[k] <= y_q[k-1];
					end
					y_q[0] <= y_new;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (step.load && !step.clr) begin
				out_q <= o_new;
			end
		end

		always_comb begin
			zero = 1'b1;
			for (int k = 0; k < TAPS; k++) begin
				if (y_q[k] != '0) begin
					zero = 1'b0;
				end
			end
		end

		assign hist_clear[b] = zero;
		assign band_out[b]   = out_q;
	end

	assign low_out  = band_out[0];
	assign high_out = band_out[1];

	`LRX_CHECK_NEXT(a_fb_hist_clear, step.load && step.clr, hist_clear == 2'b11, "band history not cleared")

endmodule

[verif/tb_crossover_filter_pair_unit.sv]
`timescale 1ns / 100ps
// self-checking stream testbench for the fourth-order crossover filter pair
module tb_crossover_filter_pair_unit;
	import lrx_pkg::*;

	localparam int SB   = SAMPLE_BITS_DEF;
	localparam int FRAC = COEF_FRAC_BITS_DEF;

	localparam int LOW_BAND  = 0;
	localparam int HIGH_BAND = 1;

	localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

	// indexes past the last register, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

	// q3.28 linkwitz-riley set, tan(pi*fc/fs) = 0.1, butterworth pair squared
	localparam int LR_DEN1      = -923209126;
	localparam int LR_DEN2      = 1198771006;
	localparam int LR_DEN3      = -696426263;
	localparam int LR_DEN4      = 152753196;
	localparam int LR_LOW_GAIN  = 20247;
	localparam int LR_HIGH_GAIN = 202474690;

	localparam int LONG_HOLD      = 48;   // receiver hold-off, fills the pipe
	localparam int SETTLE_CYCLES  = 8;    // clear words in flight give no result
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no word moving

	typedef struct {
		logic [SB-1:0] low_out;
		logic [SB-1:0] high_out;
	} band_word_t;

	// bit-true prediction of both bands plus the queue of words still due
	class crossover_bands;
		longint     den_coef[TAPS];
		longint     gain[2];
		longint     x_hist[TAPS];
		longint     y_hist[2][TAPS];
		band_word_t due_bands[$];
		int unsigned fail_count;

		function new();
			foreach (den_coef[k]) den_coef[k] = 0;
			gain[LOW_BAND]  = 0;
			gain[HIGH_BAND] = 0;
			fail_count = 0;
			clear_history();
		endfunction

		function void clear_history();
			for (int k = 0; k < TAPS; k++) begin
				x_hist[k] = 0;
				y_hist[LOW_BAND][k]  = 0;
				y_hist[HIGH_BAND][k] = 0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_DEN1, REG_DEN2, REG_DEN3, REG_DEN4: begin
					den_coef[idx[TAP_IDX_W-1:0]] = longint'($signed(val));
				end
				REG_LOW_GAIN: begin
					gain[LOW_BAND] = longint'(val[GAIN_BITS-1:0]);
				end
				REG_HIGH_GAIN: begin
					gain[HIGH_BAND] = longint'(val[GAIN_BITS-1:0]);
				end
				default: begin
				end
			endcase
		endfunction

		// round half up, arithmetic shift floors
		function longint round_up(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function longint clamp(longint v, int bits);
			longint hi;
			hi = (longint'(1) << (bits - 1)) - 1;
			if (v > hi)
				return hi;
			if (v < -hi - 1)
				return -hi - 1;
			return v;
		endfunction

		function logic [SB-1:0] band_out(int b, longint x0);
			longint acc;
			longint w;
			logic [SB-1:0] res;
			acc = round_up(gain[b] * x0, FRAC - HIST_EXTRA);
			for (int k = 0; k < TAPS; k++) begin
				w = (k == 1) ? 6 : (k == 3) ? 1 : 4;
				if (b == HIGH_BAND && k % 2 == 0)
					w = -w;
				acc += w * round_up(gain[b] * x_hist[k], FRAC - HIST_EXTRA);
			end
			for (int k = 0; k < TAPS; k++)
				acc -= round_up(den_coef[k] * y_hist[b][k], FRAC);
			for (int k = TAPS - 1; k > 0; k--)
				y_hist[b][k] = y_hist[b][k - 1];
			y_hist[b][0] = clamp(acc, HIST_BITS);
			res = SB'(clamp(round_up(acc, HIST_EXTRA), SB));
			return res;
		endfunction

		function void take_sample(bit clear, logic [SB-1:0] smp);
			band_word_t bw;
			longint x0;
			if (clear) begin
				clear_history();
				return;
			end
			x0 = longint'($signed(smp));
			bw.low_out  = band_out(LOW_BAND, x0);
			bw.high_out = band_out(HIGH_BAND, x0);
			for (int k = TAPS - 1; k > 0; k--)
				x_hist[k] = x_hist[k - 1];
			x_hist[0] = x0;
			due_bands.push_back(bw);
		endfunction

		function void report(string field, logic [SB-1:0] want, logic [SB-1:0] got);
			fail_count++;
			$error("%s mismatch: expected %0d, actual %0d", field,
				$signed(want), $signed(got));
		endfunction

		function void check_bands(logic [SB-1:0] lo, logic [SB-1:0] hi);
			band_word_t bw;
			if (due_bands.size() == 0) begin
				fail_count++;
				$error("unexpected result word: low_out %0d, high_out %0d",
					$signed(lo), $signed(hi));
				return;
			end
			bw = due_bands.pop_front();
			if (bw.low_out !== lo)
				report("low_out", bw.low_out, lo);
			if (bw.high_out !== hi)
				report("high_out", bw.high_out, hi);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SB-1:0]         s_tdata;   // sample
	logic                  s_tuser;   // cmd: 1 clears history
	logic                  m_tvalid;
	logic                  m_tready;
	logic [2*SB-1:0]       m_tdata;   // low_out, high_out
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	crossover_bands bands;
	bit             gaps_on;        // random idle bursts on the input side
	bit             stalls_on;      // random back-pressure bursts on the output side
	bit             long_hold_req;  // one long receiver hold-off, served by the ready loop
	int unsigned    quiet_cycles;

	crossover_filter_pair_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly full-range noise, with rails and small values mixed in
	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return SB'($urandom_range(0, 512) - 256);
			default: return SB'($urandom);
		endcase
	endfunction

	// offer one word, hold it until the block takes it; valid stays high after
	task automatic send_word(input bit clear, input logic [SB-1:0] smp);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= clear;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
		bands.take_sample(clear, smp);
	endtask

	task automatic run_words(input int count, input bit hold_once);
		for (int n = 0; n < count; n++) begin
			if (hold_once && n == count / 3)
				long_hold_req = 1'b1;
			send_word($urandom_range(0, 39) == 0, pick_sample());
		end
	endtask

	// drop valid, wait for every due word, then let trailing clears pass
	task automatic settle();
		s_tvalid <= 1'b0;
		while (bands.due_bands.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		bands.set_reg(idx, val);
	endtask

	// all six registers, then one write past the map that must be dropped
	task automatic program_filter(input logic [CFG_DATA_W-1:0] d1, d2, d3, d4, lg, hg);
		write_reg(REG_DEN1, d1);
		write_reg(REG_DEN2, d2);
		write_reg(REG_DEN3, d3);
		write_reg(REG_DEN4, d4);
		write_reg(REG_LOW_GAIN, lg);
		write_reg(REG_HIGH_GAIN, hg);
		write_reg($urandom_range(0, 1) ? SPARE_IDX_HI : SPARE_IDX_LO, $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// output side: random back-pressure bursts, plus the one long hold-off
	initial begin
		int unsigned hold_left;
		m_tready  = 1'b0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				hold_left = LONG_HOLD - 1;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				hold_left = $urandom_range(0, 7);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// every result word taken is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			bands.check_bands(m_tdata[SB-1:0], m_tdata[2*SB-1:SB]);
	end

	// watchdog: too long with no word moving on either side
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		bands         = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tuser       = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_DEN1;
		cfg_data      = '0;
		gaps_on       = 1'b0;
		stalls_on     = 1'b0;
		long_hold_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset, so both bands must stay at zero
		send_word(1'b0, SAMPLE_MAX);
		send_word(1'b0, SAMPLE_MIN);
		send_word(1'b0, '0);
		settle();

		// stable crossover: impulses at both rails, tiny steps, clears
		program_filter(LR_DEN1, LR_DEN2, LR_DEN3, LR_DEN4, LR_LOW_GAIN, LR_HIGH_GAIN);
		send_word(1'b0, SAMPLE_MAX);
		send_word(1'b0, '0);
		send_word(1'b0, '0);
		send_word(1'b0, '0);
		send_word(1'b0, SAMPLE_MIN);
		send_word(1'b0, SB'(1));
		send_word(1'b0, '1);
		// clear mid-stream with a nonzero sample that must be ignored
		send_word(1'b1, SAMPLE_MAX);
		send_word(1'b0, SAMPLE_MAX);
		send_word(1'b1, SAMPLE_MIN);
		send_word(1'b1, '0);
		send_word(1'b0, SAMPLE_MIN);
		settle();

		// runaway feedback: history pinned at 32-bit limits, outputs at rails
		program_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(1'b0, SAMPLE_MAX);
		send_word(1'b0, SAMPLE_MIN);
		send_word(1'b0, SAMPLE_MAX);
		send_word(1'b0, '0);
		settle();

		// random part with idling on both sides
		gaps_on   = 1'b1;
		stalls_on = 1'b1;

		program_filter(LR_DEN1, LR_DEN2, LR_DEN3, LR_DEN4, LR_LOW_GAIN, LR_HIGH_GAIN);
		run_words(500, 1'b1);
		settle();

		program_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_words(100, 1'b0);
		settle();

		program_filter(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0000_0000);
		run_words(100, 1'b0);
		settle();

		// arbitrary register contents, mostly unstable
		repeat (2) begin
			program_filter($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			run_words(200, 1'b0);
			settle();
		end

		// no feedback: pure fir bands with random gains
		program_filter('0, '0, '0, '0, $urandom, $urandom);
		run_words(200, 1'b0);
		settle();

		// closing stretch at full rate, no idling anywhere
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		program_filter(LR_DEN1, LR_DEN2, LR_DEN3, LR_DEN4, LR_LOW_GAIN, LR_HIGH_GAIN);
		run_words(200, 1'b0);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bands.fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
